[design/nearest_point_search_macros.svh]
// Assertion macros used by the checker file of this block.
// Each macro expands to one labelled concurrent assertion clocked on clk and
// switched off while rst is high.
`ifndef NEAREST_POINT_SEARCH_MACROS_SVH
`define NEAREST_POINT_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/nps_pkg.sv]
`default_nettype none

package nps_pkg;

  // Grid geometry. Entry address is col * MAX_ROWS + row.
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 32;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;

  // Coordinates and distance arithmetic.
  localparam int COORD_BITS = 24;
  localparam int ENTRY_W    = 3 * COORD_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MAG_W      = COORD_BITS;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W);
  localparam int DIST_W     = 25;

  // Configuration registers.
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic load_we;
    logic query_start;
    logic scan_step;
    logic root_start;
    logic res_load;
  } nps_cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic pipe_busy;
    logic root_done;
  } nps_stat_t;

  // Magnitude of the difference of two signed coordinates.
  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

endpackage

`default_nettype wire

[design/nearest_point_search.sv]
// Nearest point search over a grid of 3D points in signed Q16.8.
// Input channel (in_valid/in_ready): func selects a load or a query. A load
// writes coord_x/y/z into grid entry (slot_row, slot_col) on the accepting edge;
// it produces no result. A query scans the rows_in_use x cols_in_use points
// (both clamped to the grid size), one point per cycle from the grid store,
// columns outer and rows inner, and returns one result item.
// Output channel (out_valid/out_ready): found, best_row, best_col and the
// rounded-down distance. An empty scan gives found = 0 and zeros.
// From the accepting edge, a query runs the scan over the single read port of
// the store, drains the distance pipeline, runs the bit-serial square root and
// loads the output register, which raises out_valid. The block takes one item
// at a time and takes no new item until a query has loaded its output register.
// A result waits in the output register while the receiver stalls; the block
// still takes the next item and only holds a later query at its end until
// the output register is free.
// Reset sets rows_in_use to 64 and cols_in_use to 32 and empties both
// channels. Grid contents are undefined until loaded; configuration writes
// (cfg_we, cfg_index, cfg_data) are taken at once and belong to idle time.
`default_nettype none

module nearest_point_search import nps_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [ROW_W-1:0]             slot_row,
  input  logic [COL_W-1:0]             slot_col,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [ROW_W-1:0]             best_row,
  output logic [COL_W-1:0]             best_col,
  output logic [DIST_W-1:0]            distance,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  nps_cmd_t  cmd;
  nps_stat_t stat;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  nps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .slot_row  (slot_row),
    .slot_col  (slot_col),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .found     (found),
    .best_row  (best_row),
    .best_col  (best_col),
    .distance  (distance)
  );

endmodule

`default_nettype wire

[design/nps_ram.sv]
`default_nettype none

module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/nps_isqrt.sv]
`default_nettype none

module nps_isqrt import nps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  value,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [SUM_W-1:0]  val;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_shift;
  logic [REM_W-1:0]  trial;
  logic              take;

  // One root bit per cycle: bring down the next two radicand bits and try
  // subtracting four times the partial root plus one.
  always_comb begin
    rem_shift = {rem[REM_W-3:0], val[SUM_W-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
    take      = (rem_shift >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        val      <= value;
        rem      <= '0;
        root     <= '0;
        step_cnt <= '0;
      end else if (busy) begin
        val  <= val << 2;
        rem  <= take ? (rem_shift - trial) : rem_shift;
        root <= {root[ROOT_W-2:0], take};
        if (step_cnt == STEP_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step_cnt <= step_cnt + STEP_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

[design/nps_ctrl.sv]
`default_nettype none

module nps_ctrl import nps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      func,
  output logic      out_valid,
  input  logic      out_ready,
  output nps_cmd_t  cmd,
  input  nps_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_accept;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    cmd.load_we     = in_accept && (func == FUNC_LOAD);
    cmd.query_start = in_accept && (func == FUNC_QUERY);
    cmd.scan_step   = (state == ST_SCAN);
    cmd.root_start  = (state == ST_DRAIN) && !stat.pipe_busy;
    cmd.res_load    = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.query_start) begin
          state_next = stat.empty ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (stat.root_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (cmd.res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/nps_datapath.sv]
`default_nettype none

module nps_datapath import nps_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  nps_cmd_t                     cmd,
  output nps_stat_t                    stat,
  input  logic [ROW_W-1:0]             slot_row,
  input  logic [COL_W-1:0]             slot_col,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         found,
  output logic [ROW_W-1:0]             best_row,
  output logic [COL_W-1:0]             best_col,
  output logic [DIST_W-1:0]            distance
);

  logic [ROWS_CFG_W-1:0] rows_in_use;
  logic [COLS_CFG_W-1:0] cols_in_use;
  logic [ROWS_CFG_W-1:0] rows_lim;
  logic [COLS_CFG_W-1:0] cols_lim;
  logic                  row_last;
  logic                  col_last;

  logic signed [COORD_BITS-1:0] qx, qy, qz;
  logic [ROW_W-1:0] scan_row;
  logic [COL_W-1:0] scan_col;
  logic [ENTRY_W-1:0] rd_data;
  logic signed [COORD_BITS-1:0] pt_x, pt_y, pt_z;

  logic             s1_valid, s2_valid, s3_valid, s4_valid;
  logic [ROW_W-1:0] s1_row, s2_row, s3_row, s4_row;
  logic [COL_W-1:0] s1_col, s2_col, s3_col, s4_col;
  logic [MAG_W-1:0] s2_mx, s2_my, s2_mz;
  logic [SQ_W-1:0]  s3_sx, s3_sy, s3_sz;
  logic [SUM_W-1:0] s4_sum;

  logic             have;
  logic [SUM_W-1:0] best_sq;
  logic [ROW_W-1:0] best_r;
  logic [COL_W-1:0] best_c;
  logic [ROOT_W-1:0] root;
  logic             root_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_CFG_W'(MAX_ROWS);
      cols_in_use <= COLS_CFG_W'(MAX_COLS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data[ROWS_CFG_W-1:0];
        REG_COLS: cols_in_use <= cfg_data[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign rows_lim = (rows_in_use > ROWS_CFG_W'(MAX_ROWS)) ? ROWS_CFG_W'(MAX_ROWS) : rows_in_use;
  assign cols_lim = (cols_in_use > COLS_CFG_W'(MAX_COLS)) ? COLS_CFG_W'(MAX_COLS) : cols_in_use;
  assign row_last = (ROWS_CFG_W'(scan_row) == rows_lim - ROWS_CFG_W'(1));
  assign col_last = (COLS_CFG_W'(scan_col) == cols_lim - COLS_CFG_W'(1));

  // Query position and scan counters, columns outer and rows inner.
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx       <= coord_x;
      qy       <= coord_y;
      qz       <= coord_z;
      scan_row <= '0;
      scan_col <= '0;
    end else if (cmd.scan_step) begin
      if (row_last) begin
        scan_row <= '0;
        scan_col <= scan_col + COL_W'(1);
      end else begin
        scan_row <= scan_row + ROW_W'(1);
      end
    end
  end

  nps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (GRID_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr ({slot_col, slot_row}),
    .wdata ({coord_x, coord_y, coord_z}),
    .re    (cmd.scan_step),
    .raddr ({scan_col, scan_row}),
    .rdata (rd_data)
  );

  assign pt_x = rd_data[3*COORD_BITS-1 -: COORD_BITS];
  assign pt_y = rd_data[2*COORD_BITS-1 -: COORD_BITS];
  assign pt_z = rd_data[COORD_BITS-1 -: COORD_BITS];

  // Distance pipeline: read, difference magnitudes, squares, sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_step;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_row <= scan_row;
    s1_col <= scan_col;
    s2_row <= s1_row;
    s2_col <= s1_col;
    s2_mx  <= abs_diff(pt_x, qx);
    s2_my  <= abs_diff(pt_y, qy);
    s2_mz  <= abs_diff(pt_z, qz);
    s3_row <= s2_row;
    s3_col <= s2_col;
    s3_sx  <= SQ_W'(s2_mx) * SQ_W'(s2_mx);
    s3_sy  <= SQ_W'(s2_my) * SQ_W'(s2_my);
    s3_sz  <= SQ_W'(s2_mz) * SQ_W'(s2_mz);
    s4_row <= s3_row;
    s4_col <= s3_col;
    s4_sum <= SUM_W'(s3_sx) + SUM_W'(s3_sy) + SUM_W'(s3_sz);
  end

  // Only a strictly smaller distance replaces the best, so the first minimum wins.
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.query_start) begin
      have    <= 1'b0;
      best_sq <= '0;
      best_r  <= '0;
      best_c  <= '0;
    end else if (s4_valid && (!have || (s4_sum < best_sq))) begin
      have    <= 1'b1;
      best_sq <= s4_sum;
      best_r  <= s4_row;
      best_c  <= s4_col;
    end
  end

  nps_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .value (best_sq),
    .root  (root),
    .done  (root_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      found    <= have;
      best_row <= best_r;
      best_col <= best_c;
      distance <= DIST_W'(root);
    end
  end

  always_comb begin
    stat           = '0;
    stat.empty     = (rows_lim == '0) || (cols_lim == '0);
    stat.scan_last = row_last && col_last;
    stat.pipe_busy = s1_valid || s2_valid || s3_valid || s4_valid;
    stat.root_done = root_done;
  end

endmodule

`default_nettype wire

[design/nps_checker.sv]
`default_nettype none
`include "nearest_point_search_macros.svh"

module nps_checker import nps_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              func,
  input logic              out_valid,
  input logic              out_ready,
  input logic              found,
  input logic [ROW_W-1:0]  best_row,
  input logic [COL_W-1:0]  best_col,
  input logic [DIST_W-1:0] distance
);

  logic [ROW_W+COL_W+DIST_W:0] res_bits;
  logic                        in_acc;
  logic                        out_stall;
  logic                        empty_res;
  logic                        res_zero;

  assign res_bits  = {found, best_row, best_col, distance};
  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign empty_res = out_valid && !found;
  assign res_zero  = (best_row == '0) && (best_col == '0) && (distance == '0);

  // A result held back by the receiver stays put.
  `NPS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(res_bits), "held result changed")

  // An empty scan reports zeros in every field.
  `NPS_ASSERT_NOW(a_empty_zero, empty_res, res_zero, "empty result carries nonzero fields")

  // A query keeps the block busy for at least the following cycle.
  `NPS_ASSERT_NEXT(a_query_busy, in_acc && (func == FUNC_QUERY), !in_ready, "ready after a query")

  // A load completes in its own cycle.
  `NPS_ASSERT_NEXT(a_load_quick, in_acc && (func == FUNC_LOAD), in_ready, "not ready after a load")

endmodule

bind nearest_point_search nps_checker u_nps_checker (.*);

`default_nettype wire
